[design/mfrb_pkg.sv]
`timescale 1ns / 1ps

package mfrb_pkg;

  // Fixed field widths of the bus word
  localparam int OPCODE_W = 1;
  localparam int OFFSET_W = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int REG_W    = 8;
  // Channel index wide enough for the largest channel count
  localparam int CH_IDX_W = 3;

  // Register map (byte offsets)
  localparam logic [OFFSET_W-1:0] OFF_ENABLE  = 8'h20;
  localparam logic [OFFSET_W-1:0] OFF_PENDING = 8'h24;
  localparam logic [OFFSET_W-1:0] OFF_FSTAT   = 8'h50;
  localparam logic [OFFSET_W-1:0] OFF_COUNT   = 8'h60;
  localparam logic [OFFSET_W-1:0] OFF_DATA    = 8'h70;

  // Only even pending/enable bits drive the interrupt
  localparam logic [REG_W-1:0] EVEN_MASK = 8'h55;
  // Channels that own a reception-pending bit
  localparam int RX_CHANNELS = 4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_UNMAPPED
  } status_e;

  typedef enum logic [2:0] {
    KIND_ENABLE,
    KIND_PENDING,
    KIND_FSTAT,
    KIND_COUNT,
    KIND_DATA,
    KIND_UNMAPPED
  } kind_e;

  // Decoded access handed from the front to the back
  typedef struct packed {
    kind_e               kind;
    logic                is_write;
    logic [CH_IDX_W-1:0] channel;
    logic [WORD_W-1:0]   write_data;
  } cmd_t;

endpackage

[design/mfrb_intf.sv]
`timescale 1ns / 1ps

interface mfrb_req_if;
  logic                             valid;
  logic                             ready;
  logic [mfrb_pkg::OPCODE_W-1:0]    opcode;
  logic [mfrb_pkg::OFFSET_W-1:0]    reg_offset;
  logic [mfrb_pkg::WORD_W-1:0]      write_data;

  modport source (output valid, opcode, reg_offset, write_data, input ready);
  modport sink   (input valid, opcode, reg_offset, write_data, output ready);
endinterface

interface mfrb_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mfrb_pkg::WORD_W-1:0]      read_data;
  logic                             irq_line;
  logic [mfrb_pkg::STATUS_W-1:0]    access_status;

  modport source (output valid, read_data, irq_line, access_status, input ready);
  modport sink   (input valid, read_data, irq_line, access_status, output ready);
endinterface

[design/mfrb_sram.sv]
`timescale 1ns / 1ps

module mfrb_sram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write when enabled with we_i set, register read data when enabled without it
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mfrb_front.sv]
`timescale 1ns / 1ps

module mfrb_front #(
  parameter int CHANNELS = 4
) (
  mfrb_req_if.sink         req_i,
  output logic             push_valid_o,
  output mfrb_pkg::cmd_t   push_cmd_o,
  input  logic             push_ready_i
);

  localparam int OFFSET_W = mfrb_pkg::OFFSET_W;
  localparam int CH_IDX_W = mfrb_pkg::CH_IDX_W;
  localparam logic [OFFSET_W-3:0] CH_LIMIT = (OFFSET_W-2)'(CHANNELS);

  logic [OFFSET_W-1:0] d_fstat;
  logic [OFFSET_W-1:0] d_count;
  logic [OFFSET_W-1:0] d_data;
  logic                hit_fstat;
  logic                hit_count;
  logic                hit_data;

  // Distance from each per-channel bank base
  assign d_fstat = req_i.reg_offset - mfrb_pkg::OFF_FSTAT;
  assign d_count = req_i.reg_offset - mfrb_pkg::OFF_COUNT;
  assign d_data  = req_i.reg_offset - mfrb_pkg::OFF_DATA;

  // A bank hits on an aligned offset inside its channel range
  assign hit_fstat = (req_i.reg_offset >= mfrb_pkg::OFF_FSTAT) && (d_fstat[1:0] == 2'b00)
                     && (d_fstat[OFFSET_W-1:2] < CH_LIMIT);
  assign hit_count = (req_i.reg_offset >= mfrb_pkg::OFF_COUNT) && (d_count[1:0] == 2'b00)
                     && (d_count[OFFSET_W-1:2] < CH_LIMIT);
  assign hit_data  = (req_i.reg_offset >= mfrb_pkg::OFF_DATA) && (d_data[1:0] == 2'b00)
                     && (d_data[OFFSET_W-1:2] < CH_LIMIT);

  // Classify the access; earlier banks win on overlap
  always_comb begin
    push_cmd_o.is_write   = (req_i.opcode == mfrb_pkg::OP_WRITE);
    push_cmd_o.write_data = req_i.write_data;
    push_cmd_o.channel    = '0;
    if (req_i.reg_offset == mfrb_pkg::OFF_ENABLE) begin
      push_cmd_o.kind = mfrb_pkg::KIND_ENABLE;
    end else if (req_i.reg_offset == mfrb_pkg::OFF_PENDING) begin
      push_cmd_o.kind = mfrb_pkg::KIND_PENDING;
    end else if (hit_fstat) begin
      push_cmd_o.kind    = mfrb_pkg::KIND_FSTAT;
      push_cmd_o.channel = d_fstat[CH_IDX_W+1:2];
    end else if (hit_count) begin
      push_cmd_o.kind    = mfrb_pkg::KIND_COUNT;
      push_cmd_o.channel = d_count[CH_IDX_W+1:2];
    end else if (hit_data) begin
      push_cmd_o.kind    = mfrb_pkg::KIND_DATA;
      push_cmd_o.channel = d_data[CH_IDX_W+1:2];
    end else begin
      push_cmd_o.kind = mfrb_pkg::KIND_UNMAPPED;
    end
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

[design/mfrb_cmd_queue.sv]
`timescale 1ns / 1ps

module mfrb_cmd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  mfrb_pkg::cmd_t   push_cmd_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output mfrb_pkg::cmd_t   pop_cmd_o
);

  localparam int          DEPTH = 2;
  localparam logic [1:0]  COUNT_FULL = 2'(DEPTH);

  mfrb_pkg::cmd_t entries_q [DEPTH];
  logic           wr_idx_q;
  logic           rd_idx_q;
  logic [1:0]     count_q;
  logic           push;
  logic           pop;

  assign push_ready_o = (count_q != COUNT_FULL);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entries_q[rd_idx_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx_q <= ~wr_idx_q;
      end
      if (pop) begin
        rd_idx_q <= ~rd_idx_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_idx_q] <= push_cmd_i;
    end
  end

endmodule

[design/mfrb_back.sv]
`timescale 1ns / 1ps

module mfrb_back #(
  parameter int CHANNELS   = 4,
  parameter int FIFO_DEPTH = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  mfrb_pkg::cmd_t   cmd_i,
  mfrb_rsp_if.source       rsp_o
);

  localparam int WORD_W   = mfrb_pkg::WORD_W;
  localparam int REG_W    = mfrb_pkg::REG_W;
  localparam int CH_IDX_W = mfrb_pkg::CH_IDX_W;
  localparam int PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int ENTRIES  = CHANNELS * (2 ** PTR_W);
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int RX_CH    = (CHANNELS < mfrb_pkg::RX_CHANNELS) ? CHANNELS
                                                               : mfrb_pkg::RX_CHANNELS;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // Per-channel FIFO bookkeeping and interrupt registers
  logic [PTR_W-1:0] rd_ptr_q [CHANNELS];
  logic [PTR_W-1:0] rd_ptr_d [CHANNELS];
  logic [PTR_W-1:0] wr_ptr_q [CHANNELS];
  logic [PTR_W-1:0] wr_ptr_d [CHANNELS];
  logic [CNT_W-1:0] cnt_q    [CHANNELS];
  logic [CNT_W-1:0] cnt_d    [CHANNELS];
  logic [REG_W-1:0] enable_q;
  logic [REG_W-1:0] enable_d;
  logic [REG_W-1:0] pending_q;
  logic [REG_W-1:0] pending_d;

  // Result register
  logic                          out_valid_q;
  logic [WORD_W-1:0]             read_data_q;
  logic [WORD_W-1:0]             read_data_d;
  logic                          use_ram_q;
  logic                          use_ram_d;
  logic                          irq_q;
  logic                          irq_d;
  mfrb_pkg::status_e             status_q;
  mfrb_pkg::status_e             status_d;

  logic                          fire;
  logic [PTR_W-1:0]              rd_sel;
  logic [PTR_W-1:0]              wr_sel;
  logic [CNT_W-1:0]              cnt_sel;
  logic                          full;
  logic                          empty;
  logic                          push;
  logic                          pop;
  logic [CH_IDX_W+PTR_W-1:0]     addr_full;
  logic [ADDR_W-1:0]             ram_addr;
  logic [DATA_WIDTH+WORD_W-1:0]  wr_ext;
  logic [DATA_WIDTH+WORD_W-1:0]  rd_ext;
  logic [DATA_WIDTH-1:0]         ram_rdata;
  logic [RX_CH-1:0]              pend_gap;

  assign pop_ready_o = !out_valid_q || rsp_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;

  // Pick the addressed channel's pointers and count
  always_comb begin
    rd_sel  = '0;
    wr_sel  = '0;
    cnt_sel = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd_i.channel == CH_IDX_W'(c)) begin
        rd_sel  = rd_ptr_q[c];
        wr_sel  = wr_ptr_q[c];
        cnt_sel = cnt_q[c];
      end
    end
  end

  assign full  = (cnt_sel == CNT_FULL);
  assign empty = (cnt_sel == '0);
  assign push  = fire && (cmd_i.kind == mfrb_pkg::KIND_DATA) && cmd_i.is_write && !full;
  assign pop   = fire && (cmd_i.kind == mfrb_pkg::KIND_DATA) && !cmd_i.is_write && !empty;

  assign addr_full = {cmd_i.channel, (cmd_i.is_write ? wr_sel : rd_sel)};
  assign ram_addr  = addr_full[ADDR_W-1:0];
  assign wr_ext    = {{DATA_WIDTH{1'b0}}, cmd_i.write_data};

  mfrb_sram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (push || pop),
    .we_i    (push),
    .addr_i  (ram_addr),
    .wdata_i (wr_ext[DATA_WIDTH-1:0]),
    .rdata_o (ram_rdata)
  );

  // Carry out the access at the head of the queue
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cnt_d       = cnt_q;
    enable_d    = enable_q;
    pending_d   = pending_q;
    read_data_d = '0;
    use_ram_d   = 1'b0;
    status_d    = mfrb_pkg::ST_OK;
    if (fire) begin
      case (cmd_i.kind)
        mfrb_pkg::KIND_ENABLE: begin
          if (cmd_i.is_write) begin
            enable_d = cmd_i.write_data[REG_W-1:0];
          end else begin
            read_data_d = WORD_W'(enable_q);
          end
        end
        mfrb_pkg::KIND_PENDING: begin
          if (cmd_i.is_write) begin
            // Clear a pending bit only once its FIFO has drained
            for (int c = 0; c < RX_CH; c++) begin
              if (cmd_i.write_data[2*c] && (cnt_q[c] == '0)) begin
                pending_d[2*c] = 1'b0;
              end
            end
          end else begin
            read_data_d = WORD_W'(pending_q);
          end
        end
        mfrb_pkg::KIND_FSTAT: begin
          if (!cmd_i.is_write) begin
            read_data_d = WORD_W'(full);
          end
        end
        mfrb_pkg::KIND_COUNT: begin
          if (!cmd_i.is_write) begin
            read_data_d = WORD_W'(cnt_sel);
          end
        end
        mfrb_pkg::KIND_DATA: begin
          if (cmd_i.is_write) begin
            if (full) begin
              status_d = mfrb_pkg::ST_FULL;
            end
          end else if (empty) begin
            status_d = mfrb_pkg::ST_EMPTY;
          end else begin
            use_ram_d = 1'b1;
          end
        end
        mfrb_pkg::KIND_UNMAPPED: begin
          status_d = mfrb_pkg::ST_UNMAPPED;
        end
        default: begin
          status_d = mfrb_pkg::ST_UNMAPPED;
        end
      endcase
    end

    // Advance the addressed FIFO
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd_i.channel == CH_IDX_W'(c)) begin
        if (push) begin
          wr_ptr_d[c] = (wr_ptr_q[c] == PTR_LAST) ? '0 : wr_ptr_q[c] + PTR_W'(1);
          cnt_d[c]    = cnt_q[c] + CNT_W'(1);
        end
        if (pop) begin
          rd_ptr_d[c] = (rd_ptr_q[c] == PTR_LAST) ? '0 : rd_ptr_q[c] + PTR_W'(1);
          cnt_d[c]    = cnt_q[c] - CNT_W'(1);
        end
      end
    end

    // A push marks reception pending
    for (int c = 0; c < RX_CH; c++) begin
      if (push && (cmd_i.channel == CH_IDX_W'(c))) begin
        pending_d[2*c] = 1'b1;
      end
    end

    irq_d = |(enable_d & pending_d & mfrb_pkg::EVEN_MASK);
  end

  // Hold FIFO state, the enable and pending registers and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rd_ptr_q[c] <= '0;
        wr_ptr_q[c] <= '0;
        cnt_q[c]    <= '0;
      end
      enable_q    <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      cnt_q     <= cnt_d;
      enable_q  <= enable_d;
      pending_q <= pending_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_data_q <= read_data_d;
      use_ram_q   <= use_ram_d;
      irq_q       <= irq_d;
      status_q    <= status_d;
    end
  end

  // Popped words come straight from the store's read register
  assign rd_ext              = {{WORD_W{1'b0}}, ram_rdata};
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_data     = use_ram_q ? rd_ext[WORD_W-1:0] : read_data_q;
  assign rsp_o.irq_line      = irq_q;
  assign rsp_o.access_status = status_q;

  // Flag a channel that holds words but has lost its pending bit
  always_comb begin
    pend_gap = '0;
    for (int c = 0; c < RX_CH; c++) begin
      pend_gap[c] = (cnt_q[c] != '0) && !pending_q[2*c];
    end
  end

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("executed access did not produce a result");

  a_ram_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready && use_ram_q |=> $stable(ram_rdata))
    else $error("popped word changed while the result was stalled");

  a_pending_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_gap == '0)
    else $error("non-empty channel without pending bit");

  a_odd_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~mfrb_pkg::EVEN_MASK) == '0)
    else $error("odd pending bit set");

endmodule

[design/mailbox_fifo_register_block.sv]
// Four-channel mailbox register block with an 8-word FIFO per channel.
// req_i carries one bus access per word (opcode, reg_offset, write_data);
// rsp_o returns exactly one result word per access (read_data, irq_line,
// access_status), in order. Both channels handshake on valid and ready.
// An accepted access is written into the command queue; the execute stage
// then takes it from the head of the queue and loads the result register,
// which drives rsp_o.
// Throughput: one access per cycle sustained while rsp_o is ready; the execute
// stage updates the pointers, counts and the message store port once per cycle.
// A stalled receiver holds the result register; the two-entry command queue
// keeps taking accesses until it fills, then req_i.ready drops.
// Reset clears all FIFO pointers and counts, the enable and pending
// registers, the queue and the result valid flag. The message store itself
// is not cleared, since a pop only reads words that were pushed.
// irq_line reflects enable and pending state right after each access.
`timescale 1ns / 1ps

module mailbox_fifo_register_block #(
  parameter int CHANNELS   = 4,
  parameter int FIFO_DEPTH = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfrb_req_if.sink    req_i,
  mfrb_rsp_if.source  rsp_o
);

  logic           push_valid;
  logic           push_ready;
  mfrb_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  mfrb_pkg::cmd_t pop_cmd;

  mfrb_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  mfrb_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  mfrb_back #(
    .CHANNELS   (CHANNELS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int OPCODE_W     = mfrb_pkg::OPCODE_W;
  localparam int OFFSET_W     = mfrb_pkg::OFFSET_W;
  localparam int WORD_W       = mfrb_pkg::WORD_W;
  localparam int REG_W        = mfrb_pkg::REG_W;
  localparam int NUM_CH       = 4;
  localparam int DEPTH        = 8;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int RANDOM_WORDS = 1900;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 10;
  localparam int CALM_FIRST   = 900;
  localparam int CALM_LAST    = 1200;
  localparam int IDLE_PCT     = 20;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [OFFSET_W-1:0] reg_offset;
    logic [WORD_W-1:0]   write_data;
  } access_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq_line;
    mfrb_pkg::status_e access_status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mfrb_req_if req_if ();
  mfrb_rsp_if rsp_if ();

  mailbox_fifo_register_block #(
    .CHANNELS  (NUM_CH),
    .FIFO_DEPTH(DEPTH),
    .DATA_WIDTH(WORD_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the mailbox state
  logic [WORD_W-1:0] mb_store   [NUM_CH][DEPTH];
  logic [PTR_W-1:0]  mb_rd_ptr  [NUM_CH];
  logic [PTR_W-1:0]  mb_wr_ptr  [NUM_CH];
  int unsigned       mb_fill    [NUM_CH];
  logic [REG_W-1:0]  mb_enable;
  logic [REG_W-1:0]  mb_pending;

  access_t     access_q[$];
  result_t     result_q[$];
  int unsigned words_sent     = 0;
  int unsigned words_seen     = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_left      = 0;
  bit          timed_out;

  function automatic logic [OFFSET_W-1:0] chan_off(logic [OFFSET_W-1:0] base, int unsigned ch);
    return base + OFFSET_W'(4 * ch);
  endfunction

  // Channel index for base + 4*ch, or -1 when the offset does not match
  function automatic int channel_of(logic [OFFSET_W-1:0] off, logic [OFFSET_W-1:0] base);
    logic [OFFSET_W-1:0] d;
    if (off < base) return -1;
    d = off - base;
    if (d[1:0] != 2'b00 || int'(d >> 2) >= NUM_CH) return -1;
    return int'(d >> 2);
  endfunction

  // Apply one access to the shadow state and return the result word it yields
  function automatic result_t predict_access(access_t acc);
    result_t res;
    bit      wr;
    int      ch_f;
    int      ch_c;
    int      ch_d;
    res.read_data     = '0;
    res.access_status = mfrb_pkg::ST_OK;
    wr   = (acc.opcode == mfrb_pkg::OP_WRITE);
    ch_f = channel_of(acc.reg_offset, mfrb_pkg::OFF_FSTAT);
    ch_c = channel_of(acc.reg_offset, mfrb_pkg::OFF_COUNT);
    ch_d = channel_of(acc.reg_offset, mfrb_pkg::OFF_DATA);
    if (acc.reg_offset == mfrb_pkg::OFF_ENABLE) begin
      if (wr) mb_enable = acc.write_data[REG_W-1:0];
      else res.read_data = WORD_W'(mb_enable);
    end else if (acc.reg_offset == mfrb_pkg::OFF_PENDING) begin
      if (wr) begin
        // clear a pending bit only while its FIFO is empty
        for (int c = 0; c < NUM_CH; c++) begin
          if (c < mfrb_pkg::RX_CHANNELS && acc.write_data[2*c] && mb_fill[c] == 0)
            mb_pending[2*c] = 1'b0;
        end
      end else begin
        res.read_data = WORD_W'(mb_pending);
      end
    end else if (ch_f >= 0) begin
      if (!wr) res.read_data = (mb_fill[ch_f] >= DEPTH) ? WORD_W'(1) : '0;
    end else if (ch_c >= 0) begin
      if (!wr) res.read_data = WORD_W'(mb_fill[ch_c]);
    end else if (ch_d >= 0) begin
      if (wr) begin
        if (mb_fill[ch_d] >= DEPTH) begin
          res.access_status = mfrb_pkg::ST_FULL;
        end else begin
          mb_store[ch_d][mb_wr_ptr[ch_d]] = acc.write_data;
          mb_wr_ptr[ch_d] = (mb_wr_ptr[ch_d] == PTR_W'(DEPTH - 1)) ? '0 : mb_wr_ptr[ch_d] + 1'b1;
          mb_fill[ch_d]++;
          if (ch_d < mfrb_pkg::RX_CHANNELS) mb_pending[2*ch_d] = 1'b1;
        end
      end else begin
        if (mb_fill[ch_d] == 0) begin
          res.access_status = mfrb_pkg::ST_EMPTY;
        end else begin
          res.read_data = mb_store[ch_d][mb_rd_ptr[ch_d]];
          mb_rd_ptr[ch_d] = (mb_rd_ptr[ch_d] == PTR_W'(DEPTH - 1)) ? '0 : mb_rd_ptr[ch_d] + 1'b1;
          mb_fill[ch_d]--;
        end
      end
    end else begin
      res.access_status = mfrb_pkg::ST_UNMAPPED;
    end
    res.irq_line = |(mb_enable & mb_pending & mfrb_pkg::EVEN_MASK);
    return res;
  endfunction

  task automatic add_access(logic op, logic [OFFSET_W-1:0] off, logic [WORD_W-1:0] data);
    access_t acc;
    acc.opcode     = op;
    acc.reg_offset = off;
    acc.write_data = data;
    access_q.push_back(acc);
  endtask

  // Drive request words from the pending queue; predict each accepted word
  always @(posedge clk_i) begin : req_driver
    access_t acc;
    bit      idle;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        acc.opcode     = req_if.opcode;
        acc.reg_offset = req_if.reg_offset;
        acc.write_data = req_if.write_data;
        result_q.push_back(predict_access(acc));
        words_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        idle = !(words_sent >= CALM_FIRST && words_sent < CALM_LAST) &&
               ($urandom_range(99) < IDLE_PCT);
        if (access_q.size() != 0 && !idle) begin
          acc = access_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.opcode     <= acc.opcode;
          req_if.reg_offset <= acc.reg_offset;
          req_if.write_data <= acc.write_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Check result words against the oldest prediction; throttle ready
  always @(posedge clk_i) begin : rsp_monitor
    result_t want;
    bit      bad;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        words_seen++;
        bad = 1'b0;
        if (result_q.size() == 0) begin
          want = '0;
          bad  = 1'b1;
        end else begin
          want = result_q.pop_front();
          bad  = (rsp_if.read_data !== want.read_data) ||
                 (rsp_if.irq_line !== want.irq_line) ||
                 (rsp_if.access_status !== want.access_status);
        end
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            if (want == '0 && result_q.size() == 0 && words_seen > words_sent)
              $display("result word %0d arrived with nothing predicted", words_seen);
            else
              $display("word %0d: exp data=%08h irq=%0b st=%0d, got data=%08h irq=%0b st=%0d",
                       words_seen, want.read_data, want.irq_line, want.access_status,
                       rsp_if.read_data, rsp_if.irq_line, rsp_if.access_status);
          end
        end
        // hold off long enough for the block to back up into its input
        if (words_seen == 300 || words_seen == 1500) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (words_seen >= CALM_FIRST && words_seen < CALM_LAST) ||
                        ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Count cycles in which neither side moves a word
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : stimulus
    int unsigned       pick;
    int unsigned       ch;
    int unsigned       len;
    int unsigned       target;
    logic [WORD_W-1:0] data;

    req_if.valid      = 1'b0;
    req_if.opcode     = mfrb_pkg::OP_READ;
    req_if.reg_offset = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    timed_out         = 1'b0;
    mb_enable         = '0;
    mb_pending        = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      mb_rd_ptr[c] = '0;
      mb_wr_ptr[c] = '0;
      mb_fill[c]   = 0;
    end

    // Directed: reset values, empty pop, pending set and clear rules
    add_access(mfrb_pkg::OP_READ,  mfrb_pkg::OFF_ENABLE, '0);
    add_access(mfrb_pkg::OP_READ,  chan_off(mfrb_pkg::OFF_DATA, 0), '1);
    add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_ENABLE, '1);
    add_access(mfrb_pkg::OP_WRITE, chan_off(mfrb_pkg::OFF_DATA, 0), '1);
    add_access(mfrb_pkg::OP_WRITE, chan_off(mfrb_pkg::OFF_DATA, 0), '0);
    add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_PENDING, '1);
    add_access(mfrb_pkg::OP_READ,  mfrb_pkg::OFF_PENDING, '0);
    add_access(mfrb_pkg::OP_READ,  chan_off(mfrb_pkg::OFF_DATA, 0), '0);
    add_access(mfrb_pkg::OP_READ,  chan_off(mfrb_pkg::OFF_DATA, 0), '0);
    add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_PENDING, 32'hAA);
    add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_PENDING, '1);
    add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_ENABLE, '0);
    // overfill the last channel, then read its status and count
    for (int i = 0; i <= DEPTH; i++)
      add_access(mfrb_pkg::OP_WRITE, chan_off(mfrb_pkg::OFF_DATA, NUM_CH - 1), $urandom());
    add_access(mfrb_pkg::OP_READ,  chan_off(mfrb_pkg::OFF_FSTAT, NUM_CH - 1), '0);
    add_access(mfrb_pkg::OP_READ,  chan_off(mfrb_pkg::OFF_COUNT, NUM_CH - 1), '0);
    add_access(mfrb_pkg::OP_WRITE, chan_off(mfrb_pkg::OFF_FSTAT, NUM_CH - 1), '1);
    add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_ENABLE, 32'h40);
    add_access(mfrb_pkg::OP_READ,  8'h71, '1);
    add_access(mfrb_pkg::OP_WRITE, 8'hFF, '1);

    // Random: bursts that fill and drain FIFOs, mixed with single accesses
    target = access_q.size() + RANDOM_WORDS;
    while (access_q.size() < target) begin
      pick = $urandom_range(99);
      ch   = $urandom_range(NUM_CH - 1);
      len  = $urandom_range(10, 5);
      data = $urandom();
      if (pick < 8) begin
        repeat (len)
          add_access(mfrb_pkg::OP_WRITE, chan_off(mfrb_pkg::OFF_DATA, ch), $urandom());
      end else if (pick < 14) begin
        repeat (len)
          add_access(mfrb_pkg::OP_READ, chan_off(mfrb_pkg::OFF_DATA, ch), $urandom());
        add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_PENDING,
                   ($urandom_range(1) != 0) ? 32'h55 : data);
      end else if (pick < 40) begin
        add_access(mfrb_pkg::OP_WRITE, chan_off(mfrb_pkg::OFF_DATA, ch), data);
      end else if (pick < 64) begin
        add_access(mfrb_pkg::OP_READ, chan_off(mfrb_pkg::OFF_DATA, ch), data);
      end else if (pick < 70) begin
        add_access(mfrb_pkg::OP_READ, chan_off(mfrb_pkg::OFF_COUNT, ch), data);
      end else if (pick < 74) begin
        add_access(mfrb_pkg::OP_READ, chan_off(mfrb_pkg::OFF_FSTAT, ch), data);
      end else if (pick < 78) begin
        add_access(mfrb_pkg::OP_WRITE,
                   chan_off(($urandom_range(1) != 0) ? mfrb_pkg::OFF_COUNT
                                                     : mfrb_pkg::OFF_FSTAT, ch),
                   data);
      end else if (pick < 84) begin
        len = $urandom_range(2);
        add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_ENABLE,
                   (len == 0) ? data
                              : ((len == 1) ? WORD_W'(mfrb_pkg::EVEN_MASK) : 32'hFF));
      end else if (pick < 87) begin
        add_access(mfrb_pkg::OP_READ, mfrb_pkg::OFF_ENABLE, data);
      end else if (pick < 92) begin
        add_access(mfrb_pkg::OP_WRITE, mfrb_pkg::OFF_PENDING, data);
      end else if (pick < 95) begin
        add_access(mfrb_pkg::OP_READ, mfrb_pkg::OFF_PENDING, data);
      end else begin
        add_access(1'($urandom_range(1)), OFFSET_W'($urandom_range(255)), data);
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    fork
      begin
        while (access_q.size() != 0 || req_if.valid || result_q.size() != 0)
          @(negedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      begin
        wait (quiet_cycles >= STALL_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && mismatch_count == 0)
      $display("PASS mailbox_fifo_register_block");
    else
      $display("FAIL mailbox_fifo_register_block");
    $finish;
  end

endmodule

[mailbox_fifo_register_block.f]
design/mfrb_pkg.sv
design/mfrb_intf.sv
design/mfrb_sram.sv
design/mfrb_front.sv
design/mfrb_cmd_queue.sv
design/mfrb_back.sv
design/mailbox_fifo_register_block.sv
tb/tb_top.sv
